FILE: hdl/lsw_pkg.sv
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared types and constants of the lap stopwatch with split hold.
// ----------------------------------------------------------------------------
`default_nettype none

package lsw_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int DT_W       = 16;
    localparam int OP_W       = 2;
    localparam int DEN_W      = 17;
    localparam int MIN_W      = 7;
    localparam int SEC_W      = 6;
    localparam int HUN_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 1'd1;

    localparam logic [CFG_W-1:0] HOLD_MS_RESET    = 16'd4200;
    localparam logic [CFG_W-1:0] BLINK_HALF_RESET = 16'd250;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_LAP   = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

    localparam logic [DEN_W-1:0] DIV_CENTI  = 17'd10;
    localparam logic [DEN_W-1:0] DIV_HUND   = 17'd100;
    localparam logic [DEN_W-1:0] DIV_SEC    = 17'd60;
    localparam int               ROUND_MS   = 5;
    localparam logic [MIN_W-1:0] MINUTE_CAP = 7'd99;

    typedef enum logic [2:0] {
        JOB_RACE_CS,
        JOB_RACE_HUN,
        JOB_RACE_MIN,
        JOB_LAP_CS,
        JOB_LAP_HUN,
        JOB_LAP_MIN,
        JOB_BLINK
    } job_t;

    typedef struct packed {
        logic update;
        logic div_start;
        logic capture;
        logic out_load;
        job_t job;
    } lsw_cmd_t;

    typedef struct packed {
        logic div_done;
    } lsw_sts_t;

endpackage

`default_nettype wire

FILE: hdl/lsw_div.sv
// ----------------------------------------------------------------------------
// lsw_div
// Restoring divider that retires four quotient bits per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsw_div #(
    parameter int DW = 33
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [DW-1:0]                  dividend,
    input  wire logic [lsw_pkg::DEN_W-1:0]      divisor,
    output logic      [DW-1:0]                  quotient,
    output logic      [lsw_pkg::DEN_W-1:0]      remainder,
    output logic                                done
);

    localparam int STEPS = 4;
    localparam int DP    = ((DW + STEPS - 1) / STEPS) * STEPS;
    localparam int ITER  = DP / STEPS;
    localparam int CW    = $clog2(ITER + 1);
    localparam int RW    = lsw_pkg::DEN_W;

    logic [DP-1:0] sh_reg,  sh_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    always_comb
    begin
        logic [RW:0] trial;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        for (int k = 0; k < STEPS; k++)
        begin
            trial   = {rem_next, sh_next[DP-1]};
            sh_next = {sh_next[DP-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next   = RW'(trial - {1'b0, den_reg});
                sh_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[RW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(ITER);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= DP'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = sh_reg[DW-1:0];
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

FILE: hdl/lsw_ctrl.sv
// ----------------------------------------------------------------------------
// lsw_ctrl
// Sequencer of the stopwatch: event update, seven divider jobs, delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module lsw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output lsw_pkg::lsw_cmd_t        cmd,
    input  wire lsw_pkg::lsw_sts_t   sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_DELIVER
    } state_t;

    state_t             state_reg, state_next;
    lsw_pkg::job_t      job_reg,   job_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               load;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign load   = (state_reg == ST_DELIVER) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    job_next   = lsw_pkg::JOB_RACE_CS;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.div_done)
                begin
                    case (job_reg)
                        lsw_pkg::JOB_RACE_CS:  job_next = lsw_pkg::JOB_RACE_HUN;
                        lsw_pkg::JOB_RACE_HUN: job_next = lsw_pkg::JOB_RACE_MIN;
                        lsw_pkg::JOB_RACE_MIN: job_next = lsw_pkg::JOB_LAP_CS;
                        lsw_pkg::JOB_LAP_CS:   job_next = lsw_pkg::JOB_LAP_HUN;
                        lsw_pkg::JOB_LAP_HUN:  job_next = lsw_pkg::JOB_LAP_MIN;
                        lsw_pkg::JOB_LAP_MIN:  job_next = lsw_pkg::JOB_BLINK;
                        default:               job_next = lsw_pkg::JOB_BLINK;
                    endcase
                    state_next = (job_reg == lsw_pkg::JOB_BLINK) ? ST_DELIVER : ST_START;
                end
            end
            ST_DELIVER:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= lsw_pkg::JOB_RACE_CS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign cmd.update    = accept;
    assign cmd.div_start = (state_reg == ST_START);
    assign cmd.capture   = (state_reg == ST_WAIT) && sts.div_done;
    assign cmd.out_load  = load;
    assign cmd.job       = job_reg;

endmodule

`default_nettype wire

FILE: hdl/lsw_dp.sv
// ----------------------------------------------------------------------------
// lsw_dp
// Stopwatch datapath: clocks, split hold, configuration, digit split, result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsw_dp #(
    parameter int TIME_BITS = lsw_pkg::TIME_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lsw_pkg::lsw_cmd_t                 cmd,
    output lsw_pkg::lsw_sts_t                      sts,
    input  wire logic                              cfg_we,
    input  wire logic [lsw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lsw_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [lsw_pkg::OP_W-1:0]          opcode,
    input  wire logic [lsw_pkg::DT_W-1:0]          dt_ms,
    output logic      [lsw_pkg::MIN_W-1:0]         race_minutes,
    output logic      [lsw_pkg::SEC_W-1:0]         race_seconds,
    output logic      [lsw_pkg::HUN_W-1:0]         race_hundredths,
    output logic      [lsw_pkg::MIN_W-1:0]         lap_minutes,
    output logic      [lsw_pkg::SEC_W-1:0]         lap_seconds,
    output logic      [lsw_pkg::HUN_W-1:0]         lap_hundredths,
    output logic                                   lap_held,
    output logic                                   lap_bright,
    output logic                                   is_running
);

    localparam int TB = TIME_BITS;
    localparam int DW = TIME_BITS + 1;
    localparam int DT = lsw_pkg::DT_W;

    logic [TB-1:0] race_reg,  race_next;
    logic [TB-1:0] lap_reg,   lap_next;
    logic [TB-1:0] split_reg, split_next;
    logic          split_valid_reg, split_valid_next;
    logic [DT-1:0] hold_rem_reg, hold_rem_next;
    logic [TB-1:0] blink_reg, blink_next;
    logic          run_reg,   run_next;
    logic [lsw_pkg::CFG_W-1:0] hold_ms_reg;
    logic [lsw_pkg::CFG_W-1:0] blink_half_reg;

    logic [DW-1:0] race_sum, lap_sum, blink_sum;
    logic [TB-1:0] race_sat, lap_sat, blink_sat;
    logic          held;
    logic [TB-1:0] shown;

    logic [DW-1:0]                 div_dividend;
    logic [lsw_pkg::DEN_W-1:0]     div_divisor;
    logic [DW-1:0]                 div_quo;
    logic [lsw_pkg::DEN_W-1:0]     div_rem;
    logic                          div_done;
    logic [lsw_pkg::MIN_W-1:0]     min_capped;

    logic [lsw_pkg::MIN_W-1:0] w_race_min_reg, w_lap_min_reg;
    logic [lsw_pkg::SEC_W-1:0] w_race_sec_reg, w_lap_sec_reg;
    logic [lsw_pkg::HUN_W-1:0] w_race_hun_reg, w_lap_hun_reg;
    logic                      w_bright_reg;

    logic [lsw_pkg::MIN_W-1:0] o_race_min_reg, o_lap_min_reg;
    logic [lsw_pkg::SEC_W-1:0] o_race_sec_reg, o_lap_sec_reg;
    logic [lsw_pkg::HUN_W-1:0] o_race_hun_reg, o_lap_hun_reg;
    logic                      o_held_reg, o_bright_reg, o_run_reg;

    assign race_sum  = {1'b0, race_reg}  + DW'(dt_ms);
    assign lap_sum   = {1'b0, lap_reg}   + DW'(dt_ms);
    assign blink_sum = {1'b0, blink_reg} + DW'(dt_ms);
    assign race_sat  = race_sum[TB]  ? '1 : race_sum[TB-1:0];
    assign lap_sat   = lap_sum[TB]   ? '1 : lap_sum[TB-1:0];
    assign blink_sat = blink_sum[TB] ? '1 : blink_sum[TB-1:0];

    always_comb
    begin
        race_next        = race_reg;
        lap_next         = lap_reg;
        split_next       = split_reg;
        split_valid_next = split_valid_reg;
        hold_rem_next    = hold_rem_reg;
        blink_next       = blink_reg;
        run_next         = run_reg;
        case (opcode)
            lsw_pkg::OP_TICK:
            begin
                if (hold_rem_reg != '0)
                begin
                    if (dt_ms >= hold_rem_reg)
                    begin
                        hold_rem_next    = '0;
                        split_valid_next = 1'b0;
                        blink_next       = '0;
                    end
                    else
                    begin
                        hold_rem_next = hold_rem_reg - dt_ms;
                        blink_next    = blink_sat;
                    end
                end
                if (run_reg)
                begin
                    race_next = race_sat;
                    lap_next  = lap_sat;
                end
            end
            lsw_pkg::OP_START:
            begin
                race_next        = '0;
                lap_next         = '0;
                split_next       = '0;
                split_valid_next = 1'b0;
                hold_rem_next    = '0;
                blink_next       = '0;
                run_next         = 1'b1;
            end
            lsw_pkg::OP_LAP:
            begin
                if (run_reg)
                begin
                    split_next       = lap_reg;
                    split_valid_next = 1'b1;
                    hold_rem_next    = hold_ms_reg;
                    blink_next       = '0;
                    lap_next         = '0;
                end
            end
            default:
            begin
                run_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            race_reg        <= '0;
            lap_reg         <= '0;
            split_reg       <= '0;
            split_valid_reg <= 1'b0;
            hold_rem_reg    <= '0;
            blink_reg       <= '0;
            run_reg         <= 1'b0;
            hold_ms_reg     <= lsw_pkg::HOLD_MS_RESET;
            blink_half_reg  <= lsw_pkg::BLINK_HALF_RESET;
        end
        else
        begin
            if (cmd.update)
            begin
                race_reg        <= race_next;
                lap_reg         <= lap_next;
                split_reg       <= split_next;
                split_valid_reg <= split_valid_next;
                hold_rem_reg    <= hold_rem_next;
                blink_reg       <= blink_next;
                run_reg         <= run_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lsw_pkg::CFG_HOLD_MS:    hold_ms_reg    <= cfg_data;
                    lsw_pkg::CFG_BLINK_HALF: blink_half_reg <= cfg_data;
                    default:                 hold_ms_reg    <= hold_ms_reg;
                endcase
            end
        end
    end

    assign held  = (hold_rem_reg != '0) && split_valid_reg;
    assign shown = held ? split_reg : lap_reg;

    always_comb
    begin
        case (cmd.job)
            lsw_pkg::JOB_RACE_CS:
            begin
                div_dividend = {1'b0, race_reg} + DW'(lsw_pkg::ROUND_MS);
                div_divisor  = lsw_pkg::DIV_CENTI;
            end
            lsw_pkg::JOB_LAP_CS:
            begin
                div_dividend = {1'b0, shown} + DW'(lsw_pkg::ROUND_MS);
                div_divisor  = lsw_pkg::DIV_CENTI;
            end
            lsw_pkg::JOB_RACE_HUN, lsw_pkg::JOB_LAP_HUN:
            begin
                div_dividend = div_quo;
                div_divisor  = lsw_pkg::DIV_HUND;
            end
            lsw_pkg::JOB_RACE_MIN, lsw_pkg::JOB_LAP_MIN:
            begin
                div_dividend = div_quo;
                div_divisor  = lsw_pkg::DIV_SEC;
            end
            default:
            begin
                div_dividend = {1'b0, blink_reg};
                div_divisor  = {blink_half_reg, 1'b0};
            end
        endcase
    end

    lsw_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign sts.div_done = div_done;
    assign min_capped   = (div_quo > DW'(lsw_pkg::MINUTE_CAP))
                          ? lsw_pkg::MINUTE_CAP : div_quo[lsw_pkg::MIN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            case (cmd.job)
                lsw_pkg::JOB_RACE_HUN:
                begin
                    w_race_hun_reg <= div_rem[lsw_pkg::HUN_W-1:0];
                end
                lsw_pkg::JOB_RACE_MIN:
                begin
                    w_race_sec_reg <= div_rem[lsw_pkg::SEC_W-1:0];
                    w_race_min_reg <= min_capped;
                end
                lsw_pkg::JOB_LAP_HUN:
                begin
                    w_lap_hun_reg <= div_rem[lsw_pkg::HUN_W-1:0];
                end
                lsw_pkg::JOB_LAP_MIN:
                begin
                    w_lap_sec_reg <= div_rem[lsw_pkg::SEC_W-1:0];
                    w_lap_min_reg <= min_capped;
                end
                lsw_pkg::JOB_BLINK:
                begin
                    w_bright_reg <= !held || (blink_half_reg == '0)
                                    || (div_rem < {1'b0, blink_half_reg});
                end
                default:
                begin
                    w_bright_reg <= w_bright_reg;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            o_race_min_reg <= w_race_min_reg;
            o_race_sec_reg <= w_race_sec_reg;
            o_race_hun_reg <= w_race_hun_reg;
            o_lap_min_reg  <= w_lap_min_reg;
            o_lap_sec_reg  <= w_lap_sec_reg;
            o_lap_hun_reg  <= w_lap_hun_reg;
            o_held_reg     <= held;
            o_bright_reg   <= w_bright_reg;
            o_run_reg      <= run_reg;
        end
    end

    assign race_minutes    = o_race_min_reg;
    assign race_seconds    = o_race_sec_reg;
    assign race_hundredths = o_race_hun_reg;
    assign lap_minutes     = o_lap_min_reg;
    assign lap_seconds     = o_lap_sec_reg;
    assign lap_hundredths  = o_lap_hun_reg;
    assign lap_held        = o_held_reg;
    assign lap_bright      = o_bright_reg;
    assign is_running      = o_run_reg;

endmodule

`default_nettype wire

FILE: hdl/lap_stopwatch_with_split_hold_top.sv
// ----------------------------------------------------------------------------
// lap_stopwatch_with_split_hold_top
// Race stopwatch with a lap clock and a blinking held lap split.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid/in_stall    opcode, dt_ms
//   out      source     out_valid/out_stall  race and lap time digits, flags
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// A request is accepted in the idle step; the shared divider then serves seven jobs
// in turn, four bits a cycle, and the result is loaded in the deliver step.
// One request is in work at a time; the next is taken while a result waits, and its
// own result then waits in the deliver step until the waiting one is taken.
// Reset is asynchronous and active low and restores the power-up registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_stopwatch_with_split_hold_top #(
    parameter int TIME_BITS = lsw_pkg::TIME_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lsw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lsw_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lsw_pkg::OP_W-1:0]          opcode,
    input  wire logic [lsw_pkg::DT_W-1:0]          dt_ms,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [lsw_pkg::MIN_W-1:0]         race_minutes,
    output logic      [lsw_pkg::SEC_W-1:0]         race_seconds,
    output logic      [lsw_pkg::HUN_W-1:0]         race_hundredths,
    output logic      [lsw_pkg::MIN_W-1:0]         lap_minutes,
    output logic      [lsw_pkg::SEC_W-1:0]         lap_seconds,
    output logic      [lsw_pkg::HUN_W-1:0]         lap_hundredths,
    output logic                                   lap_held,
    output logic                                   lap_bright,
    output logic                                   is_running
);

    lsw_pkg::lsw_cmd_t cmd;
    lsw_pkg::lsw_sts_t sts;

    lsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lsw_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .dt_ms           (dt_ms),
        .race_minutes    (race_minutes),
        .race_seconds    (race_seconds),
        .race_hundredths (race_hundredths),
        .lap_minutes     (lap_minutes),
        .lap_seconds     (lap_seconds),
        .lap_hundredths  (lap_hundredths),
        .lap_held        (lap_held),
        .lap_bright      (lap_bright),
        .is_running      (is_running)
    );

endmodule

`default_nettype wire

FILE: hdl/lsw_checker.sv
// ----------------------------------------------------------------------------
// lsw_checker
// Port-level checks of the stopwatch, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsw_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [lsw_pkg::MIN_W-1:0]     race_minutes,
    input wire logic [lsw_pkg::SEC_W-1:0]     race_seconds,
    input wire logic [lsw_pkg::HUN_W-1:0]     race_hundredths,
    input wire logic [lsw_pkg::MIN_W-1:0]     lap_minutes,
    input wire logic [lsw_pkg::SEC_W-1:0]     lap_seconds,
    input wire logic [lsw_pkg::HUN_W-1:0]     lap_hundredths,
    input wire logic                          lap_held,
    input wire logic                          lap_bright
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Stalled result was withdrawn.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(race_minutes) && $stable(lap_minutes)
            && $stable(race_hundredths) && $stable(lap_hundredths) && $stable(lap_held))
        else $error("Stalled result changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Block took a second request while the first was in work.");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> race_minutes <= 7'd99 && race_seconds <= 6'd59
            && race_hundredths <= 7'd99 && lap_minutes <= 7'd99
            && lap_seconds <= 6'd59 && lap_hundredths <= 7'd99)
        else $error("Time digit out of range.");

    a_bright_unheld: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !lap_held |-> lap_bright)
        else $error("Lap time dimmed while not held.");

endmodule

bind lap_stopwatch_with_split_hold_top lsw_checker u_lsw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .race_minutes    (race_minutes),
    .race_seconds    (race_seconds),
    .race_hundredths (race_hundredths),
    .lap_minutes     (lap_minutes),
    .lap_seconds     (lap_seconds),
    .lap_hundredths  (lap_hundredths),
    .lap_held        (lap_held),
    .lap_bright      (lap_bright)
);

`default_nettype wire
